// File: hdl/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication or plain property checked on the rising clock edge
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("property violated");

// condition that must never be seen on a clock edge
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// File: hdl/ibp_pkg.sv
`default_nettype none

package ibp_pkg;

   // store limits
   localparam int MAX_WIDTH    = 64;
   localparam int MAX_HEIGHT   = 64;
   localparam int MAX_CHANNELS = 4;
   localparam int MAX_PAD      = 16;
   localparam int STORE_DEPTH  = MAX_HEIGHT * MAX_WIDTH * MAX_CHANNELS;
   localparam int MAX_DIM      = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;

   // field and register widths
   localparam int COORD_W = 7;
   localparam int CHAN_W  = 2;
   localparam int BYTE_W  = 8;
   localparam int LEN_W   = 7;
   localparam int CNT_W   = 3;
   localparam int PAD_W   = 5;
   localparam int MODE_W  = 3;
   localparam int FILL_W  = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   // derived widths
   localparam int ROW_IDX_W = $clog2(MAX_HEIGHT);
   localparam int COL_IDX_W = $clog2(MAX_WIDTH);
   localparam int CH_IDX_W  = $clog2(MAX_CHANNELS);
   localparam int ADDR_W    = $clog2(STORE_DEPTH);
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int POS_W     = COORD_W + 1;
   localparam int MAG_W     = COORD_W;
   localparam int MOD_W     = LEN_W + 1;
   localparam int SHIFT_W   = MOD_W + MAG_W;
   localparam int STEP_W    = $clog2(MAG_W);

   // border modes
   localparam logic [MODE_W-1:0] MODE_CONSTANT   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_REPLICATE  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_REFLECT    = 3'd2;
   localparam logic [MODE_W-1:0] MODE_WRAP       = 3'd3;
   localparam logic [MODE_W-1:0] MODE_REFLECT101 = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_TOP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_LEFT    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BORDER_MODE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_FILL_BYTES  = 3'd6;

   // item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // request to a coordinate mapper
   typedef struct packed {
      logic signed [POS_W-1:0] pos;
      logic [LEN_W-1:0]        len;
      logic [MODE_W-1:0]       mode;
   } map_req_type;

   // answer from a coordinate mapper
   typedef struct packed {
      logic             outside;
      logic [IDX_W-1:0] index;
   } map_res_type;

endpackage

`default_nettype wire

// File: hdl/image_border_padding.sv
// load items: one per cycle while no read item is in flight, written to the frame store at the accept edge, no result
// read items: result register loaded after the map and last states when both coordinates map
// directly, and also after 7 compare-subtract steps and a fold when a reflect or wrap remainder runs
// the next item is taken once the read result register is loaded, later while a result is stalled
// reset is synchronous and active high: config and control registers return to defaults, store is not cleared
`default_nettype none

module image_border_padding
   import ibp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic                  req_kind,
   input  wire logic [COORD_W-1:0]    req_row,
   input  wire logic [COORD_W-1:0]    req_col,
   input  wire logic [CHAN_W-1:0]     req_channel,
   input  wire logic [BYTE_W-1:0]     req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [BYTE_W-1:0]     rsp_pixel_value,
   output logic                       rsp_used_fill
);

   `include "assert_macros.svh"

   localparam logic [1:0] T_IDLE = 2'd0;
   localparam logic [1:0] T_MAP  = 2'd1;
   localparam logic [1:0] T_LAST = 2'd2;

   // configuration registers
   logic [LEN_W-1:0]  src_width_ff, src_height_ff;
   logic [CNT_W-1:0]  channels_ff;
   logic [PAD_W-1:0]  pad_top_ff, pad_left_ff;
   logic [MODE_W-1:0] border_mode_ff;
   logic [FILL_W-1:0] fill_bytes_ff;

   // sequencer state
   logic [1:0]        state_ff, state_in;
   logic              row_seen_ff, row_seen_in;
   logic              col_seen_ff, col_seen_in;
   logic [CHAN_W-1:0] ch_ff, ch_in;
   logic              mem_ff, mem_in;
   logic [BYTE_W-1:0] val_ff, val_in;
   logic              fill_ff, fill_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_value_ff, rsp_value_in;
   logic              rsp_fill_ff, rsp_fill_in;

   logic [LEN_W-1:0]  width_sat, height_sat;
   logic [CNT_W-1:0]  chan_sat;
   logic [PAD_W-1:0]  top_sat, left_sat;
   logic [MODE_W-1:0] mode_sat;

   logic              req_accept;
   logic              start;
   map_req_type       row_req, col_req;
   logic              row_done, col_done;
   map_res_type       row_res, col_res;
   logic              both_done;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_waddr, ram_raddr;
   logic [BYTE_W-1:0] ram_rdata;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         src_width_ff   <= LEN_W'(MAX_WIDTH);
         src_height_ff  <= LEN_W'(MAX_HEIGHT);
         channels_ff    <= CNT_W'(1);
         pad_top_ff     <= '0;
         pad_left_ff    <= '0;
         border_mode_ff <= MODE_REPLICATE;
         fill_bytes_ff  <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_SRC_WIDTH:   src_width_ff   <= csr_data[LEN_W-1:0];
            REG_SRC_HEIGHT:  src_height_ff  <= csr_data[LEN_W-1:0];
            REG_CHANNELS:    channels_ff    <= csr_data[CNT_W-1:0];
            REG_PAD_TOP:     pad_top_ff     <= csr_data[PAD_W-1:0];
            REG_PAD_LEFT:    pad_left_ff    <= csr_data[PAD_W-1:0];
            REG_BORDER_MODE: border_mode_ff <= csr_data[MODE_W-1:0];
            REG_FILL_BYTES:  fill_bytes_ff  <= csr_data[FILL_W-1:0];
            default: ;
         endcase
      end
   end

   // clamp registers to their legal ranges
   always_comb begin
      width_sat  = (src_width_ff == '0) ? LEN_W'(1) :
                   (src_width_ff > LEN_W'(MAX_WIDTH)) ? LEN_W'(MAX_WIDTH) : src_width_ff;
      height_sat = (src_height_ff == '0) ? LEN_W'(1) :
                   (src_height_ff > LEN_W'(MAX_HEIGHT)) ? LEN_W'(MAX_HEIGHT) : src_height_ff;
      chan_sat   = (channels_ff == '0) ? CNT_W'(1) :
                   (channels_ff > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : channels_ff;
      top_sat    = (pad_top_ff > PAD_W'(MAX_PAD)) ? PAD_W'(MAX_PAD) : pad_top_ff;
      left_sat   = (pad_left_ff > PAD_W'(MAX_PAD)) ? PAD_W'(MAX_PAD) : pad_left_ff;
      mode_sat   = (border_mode_ff > MODE_REFLECT101) ? MODE_CONSTANT : border_mode_ff;
   end

   // input handshake
   assign req_stall  = (state_ff != T_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign start      = req_accept && (req_kind == KIND_READ);

   // positions relative to the source origin
   always_comb begin
      row_req.pos  = POS_W'(req_row) - POS_W'(top_sat);
      row_req.len  = height_sat;
      row_req.mode = mode_sat;
      col_req.pos  = POS_W'(req_col) - POS_W'(left_sat);
      col_req.len  = width_sat;
      col_req.mode = mode_sat;
   end

   ibp_coord_map u_row_map (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (row_req),
      .done  (row_done),
      .res   (row_res)
   );

   ibp_coord_map u_col_map (
      .clock (clock),
      .reset (reset),
      .start (start),
      .req   (col_req),
      .done  (col_done),
      .res   (col_res)
   );

   assign both_done = (row_seen_ff || row_done) && (col_seen_ff || col_done);

   // frame store ports: loads write at accept, reads issue once both maps are in
   always_comb begin
      ram_we    = req_accept && (req_kind == KIND_LOAD) &&
                  (req_row < COORD_W'(MAX_HEIGHT)) && (req_col < COORD_W'(MAX_WIDTH)) &&
                  ({1'b0, req_channel} < (CHAN_W + 1)'(MAX_CHANNELS));
      ram_waddr = {req_row[ROW_IDX_W-1:0], req_col[COL_IDX_W-1:0],
                   req_channel[CH_IDX_W-1:0]};
      ram_re    = (state_ff == T_MAP) && both_done &&
                  (CNT_W'(ch_ff) < chan_sat) && !row_res.outside && !col_res.outside;
      ram_raddr = {row_res.index[ROW_IDX_W-1:0], col_res.index[COL_IDX_W-1:0],
                   ch_ff[CH_IDX_W-1:0]};
   end

   ibp_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (STORE_DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (req_data),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // read item sequencer and result register
   always_comb begin
      state_in     = state_ff;
      row_seen_in  = row_seen_ff || row_done;
      col_seen_in  = col_seen_ff || col_done;
      ch_in        = ch_ff;
      mem_in       = mem_ff;
      val_in       = val_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_fill_in  = rsp_fill_ff;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               ch_in       = req_channel;
               row_seen_in = 1'b0;
               col_seen_in = 1'b0;
               state_in    = T_MAP;
            end
         end
         T_MAP: begin
            if (both_done) begin
               state_in = T_LAST;
               mem_in   = 1'b0;
               fill_in  = 1'b0;
               val_in   = '0;
               if (CNT_W'(ch_ff) >= chan_sat) begin
                  val_in = '0;
               end else if (row_res.outside || col_res.outside) begin
                  val_in  = BYTE_W'(fill_bytes_ff >> {ch_ff, 3'b000});
                  fill_in = 1'b1;
               end else begin
                  mem_in = 1'b1;
               end
            end
         end
         T_LAST: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = mem_ff ? ram_rdata : val_ff;
               rsp_fill_in  = fill_ff;
               state_in     = T_IDLE;
            end
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         row_seen_ff  <= 1'b0;
         col_seen_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_seen_ff  <= row_seen_in;
         col_seen_ff  <= col_seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ch_ff        <= ch_in;
      mem_ff       <= mem_in;
      val_ff       <= val_in;
      fill_ff      <= fill_in;
      rsp_value_ff <= rsp_value_in;
      rsp_fill_ff  <= rsp_fill_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_value = rsp_value_ff;
   assign rsp_used_fill   = rsp_fill_ff;

   // loads never overlap a read item in flight
   `ASSERT_PROP(a_write_when_idle, clock, reset, ram_we |-> (state_ff == T_IDLE))
   // store read needs both mapped coordinates
   `ASSERT_PROP(a_read_after_map, clock, reset, ram_re |-> both_done)
   // the cycle right after a store read is the last state with the read data selected
   `ASSERT_PROP(a_read_then_last, clock, reset, ram_re |=> (state_ff == T_LAST && mem_ff))

endmodule

`default_nettype wire

// File: hdl/ibp_ram.sv
`default_nettype none

module ibp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: hdl/ibp_coord_map.sv
`default_nettype none

module ibp_coord_map
   import ibp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire map_req_type req,
   output logic             done,
   output map_res_type      res
);

   `include "assert_macros.svh"

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FOLD = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MAG_W-1:0]  x_ff, x_in;
   logic [MOD_W-1:0]  m_ff, m_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [MODE_W-1:0] mode_ff, mode_in;
   logic              neg_ff, neg_in;
   logic              done_ff, done_in;
   map_res_type       res_ff, res_in;

   logic              neg;
   logic [MAG_W-1:0]  mag;
   logic              in_range;
   logic [SHIFT_W-1:0] shifted;
   logic [MOD_W-1:0]  rem;
   logic [MOD_W-1:0]  folded;

   // magnitude and range of the incoming position
   always_comb begin
      neg      = req.pos[POS_W-1];
      mag      = neg ? MAG_W'(-req.pos) : req.pos[MAG_W-1:0];
      in_range = !neg && (mag < req.len);
   end

   // remainder step: divisor shifted to the current bit
   assign shifted = SHIFT_W'(m_ff) << step_ff;

   // true remainder and fold back into the source
   always_comb begin
      rem = (neg_ff && (x_ff != '0)) ? (m_ff - MOD_W'(x_ff)) : MOD_W'(x_ff);
      if (mode_ff == MODE_WRAP || rem < MOD_W'(len_ff)) begin
         folded = rem;
      end else if (mode_ff == MODE_REFLECT) begin
         folded = m_ff - MOD_W'(1) - rem;
      end else begin
         folded = m_ff - rem;
      end
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      x_in     = x_ff;
      m_in     = m_ff;
      len_in   = len_ff;
      mode_in  = mode_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      res_in   = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               len_in  = req.len;
               mode_in = req.mode;
               neg_in  = neg;
               x_in    = mag;
               step_in = STEP_W'(MAG_W - 1);
               res_in.outside = 1'b0;
               if (in_range) begin
                  res_in.index = IDX_W'(mag);
                  done_in      = 1'b1;
               end else begin
                  unique case (req.mode) inside
                     MODE_REPLICATE: begin
                        res_in.index = neg ? '0 : IDX_W'(req.len - LEN_W'(1));
                        done_in      = 1'b1;
                     end
                     MODE_REFLECT, MODE_REFLECT101: begin
                        m_in = (req.mode == MODE_REFLECT) ? {req.len, 1'b0}
                                                          : {req.len, 1'b0} - MOD_W'(2);
                        if (req.len == LEN_W'(1)) begin
                           res_in.index = '0;
                           done_in      = 1'b1;
                        end else begin
                           state_in = ST_DIV;
                        end
                     end
                     MODE_WRAP: begin
                        m_in     = MOD_W'(req.len);
                        state_in = ST_DIV;
                     end
                     default: begin
                        res_in.outside = 1'b1;
                        res_in.index   = '0;
                        done_in        = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_DIV: begin
            if (SHIFT_W'(x_ff) >= shifted) begin
               x_in = MAG_W'(SHIFT_W'(x_ff) - shifted);
            end
            if (step_ff == '0) begin
               state_in = ST_FOLD;
            end else begin
               step_in = step_ff - STEP_W'(1);
            end
         end
         ST_FOLD: begin
            res_in.outside = 1'b0;
            res_in.index   = IDX_W'(folded);
            done_in        = 1'b1;
            state_in       = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      x_ff    <= x_in;
      m_ff    <= m_in;
      len_ff  <= len_in;
      mode_ff <= mode_in;
      neg_ff  <= neg_in;
      res_ff  <= res_in;
   end

   assign done = done_ff;
   assign res  = res_ff;

   // a mapped index always lands inside the source
   `ASSERT_PROP(a_index_in_range, clock, reset,
      (done_ff && !res_ff.outside) |-> ({1'b0, res_ff.index} < len_ff))
   // an answer only follows a start or the fold cycle
   `ASSERT_PROP(a_done_source, clock, reset,
      done_ff |-> $past(state_ff == ST_FOLD || (start && state_ff == ST_IDLE)))
   // a new coordinate only arrives while the mapper is idle
   `ASSERT_NEVER(a_start_busy, clock, reset, start && (state_ff != ST_IDLE))

endmodule

`default_nettype wire
